// ----- rtl/sdp_pkg.sv -----
// shared types, constants and saturating adders for the sph density/pressure engine
package sdp_pkg;

  localparam int unsigned MAX_PARTICLES = 1024;
  localparam int unsigned PIDX_W        = $clog2(MAX_PARTICLES);
  localparam int unsigned IDX_W         = 10;
  localparam int unsigned ACT_W         = 3;
  localparam int unsigned CFG_AW        = 2;
  localparam int unsigned IN_TDATA_W    = 144;
  localparam int unsigned OUT_TDATA_W   = 168;
  localparam int unsigned OP_W          = 42;
  localparam int unsigned CHUNK_W       = 14;
  localparam int unsigned ACC_W         = 2 * OP_W;
  localparam int unsigned SHR_W         = ACC_W - 16;

  localparam logic [ACT_W-1:0] ACT_LOAD = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DENS = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INV  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PRES = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ = 3'd4;

  localparam logic [CFG_AW-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_REST   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_POLY6  = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_SPIKY  = 2'd3;

  localparam logic [31:0] RADIUS_RST = 32'd65536;
  localparam logic [31:0] REST_RST   = 32'd65536;
  localparam logic [31:0] POLY6_RST  = 32'd102675;
  localparam logic [31:0] SPIKY_RST  = 32'hFFF1_AD12;

  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;
  localparam logic [39:0] S40_MAX = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] S40_MIN = 40'h80_0000_0000;

  localparam logic [SHR_W-1:0] LIM_U    = SHR_W'(68'h0_FFFF_FFFF);
  localparam logic [SHR_W-1:0] LIM_SPOS = SHR_W'(68'h7F_FFFF_FFFF);
  localparam logic [SHR_W-1:0] LIM_SNEG = SHR_W'(68'h80_0000_0000);

  typedef struct packed {
    logic        sat;
    logic [39:0] pz;
    logic [39:0] py;
    logic [39:0] px;
    logic [31:0] inv;
    logic [31:0] dens;
    logic [31:0] mass;
  } sdp_rec_t;

  typedef struct packed {
    logic            start;
    logic            uns;
    logic [OP_W-1:0] op_a;
    logic [OP_W-1:0] op_b;
  } sdp_mreq_t;

  typedef struct packed {
    logic            done;
    logic            sat;
    logic [OP_W-1:0] res;
  } sdp_mrsp_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sdp_usum_t;

  typedef struct packed {
    logic        sat;
    logic [39:0] val;
  } sdp_psum_t;

  function automatic sdp_usum_t add_dens(logic [31:0] d, logic [31:0] t);
    logic [32:0] s;
    sdp_usum_t   r;
    s = {1'b0, d} + {1'b0, t};
    r.sat = s[32];
    r.val = s[32] ? U32_MAX : s[31:0];
    return r;
  endfunction

  function automatic sdp_psum_t add_pres(logic [39:0] p, logic [OP_W-1:0] t);
    logic signed [42:0] s;
    sdp_psum_t          r;
    s = $signed({{3{p[39]}}, p}) + $signed({t[OP_W-1], t});
    if (s > $signed({3'b000, S40_MAX})) begin
      r.sat = 1'b1;
      r.val = S40_MAX;
    end else if (s < $signed({3'b111, S40_MIN})) begin
      r.sat = 1'b1;
      r.val = S40_MIN;
    end else begin
      r.sat = 1'b0;
      r.val = s[39:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/sph_density_pressure_engine.sv -----
// top level: particle table, sequencer and shared arithmetic for sph density and pressure
//
// input words arrive on s_axis: tuser carries the action (load, density pair, invert,
// pressure pair, read), tdata the indices, mass, distance and unit direction.
// only a read produces an output word on m_axis; every other action updates the table.
// config registers (radius, rest density, poly6 scale, spiky scale) are written through
// cfg_we_i/cfg_addr_i/cfg_data_i, by the user only while the engine is idle (unchecked).
// one item at a time: s_axis_tready is high only while the sequencer waits for work.
// every product goes through one shared multiplier, one product at a time:
//   density pair six products, pressure pair thirteen, invert 33 divider steps.
// the table has one read port with registered read and one write port; each item reads
// its particles, works on copies and, unless it is a read, writes them back.
// a read waits in its output stage while an earlier word is still stalled on m_axis.
// reset returns the sequencer to idle and the registers to their defaults; table
// contents are not cleared and must be loaded before use.
module sph_density_pressure_engine import sdp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // first_index, second_index, mass, distance, dir_x, dir_y, dir_z
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // action
  input  logic [ACT_W-1:0]       s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_index, out_density, out_pressure_x, out_pressure_y, out_pressure_z, saturated
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [CFG_AW-1:0]      cfg_addr_i,
  input  logic [31:0]            cfg_data_i
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RDA   = 4'd1;
  localparam logic [3:0] ST_RDB   = 4'd2;
  localparam logic [3:0] ST_RDC   = 4'd3;
  localparam logic [3:0] ST_DISP  = 4'd4;
  localparam logic [3:0] ST_MGO   = 4'd5;
  localparam logic [3:0] ST_MWAIT = 4'd6;
  localparam logic [3:0] ST_DWAIT = 4'd7;
  localparam logic [3:0] ST_WRA   = 4'd8;
  localparam logic [3:0] ST_WRB   = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  localparam logic [3:0] DENS_LAST = 4'd5;
  localparam logic [3:0] PRES_LAST = 4'd12;

  logic [3:0]  state_q, state_d;
  logic [3:0]  step_q;
  logic [31:0] radius_q, rest_q, poly6_q, spiky_q;

  logic [ACT_W-1:0] act_q;
  logic [IDX_W-1:0] ia_q, ib_q;
  logic [31:0]      mass_q, dist_q;
  logic [17:0]      dx_q, dy_q, dz_q;
  logic             hit_q;
  logic [OP_W-1:0]  t0_q, t1_q, t0_n, t1_n;

  sdp_rec_t mem_q [MAX_PARTICLES];
  sdp_rec_t rd_q, rec_a_q, rec_b_q, rec_a_n, rec_b_n, wdata;
  logic [PIDX_W-1:0] raddr, waddr;
  logic              mem_we;

  sdp_mreq_t mreq;
  sdp_mrsp_t mrsp;
  logic        div_start, div_done;
  logic [32:0] div_quo;

  logic        out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  sdp_rec_t    out_rec_q;
  logic        out_load;

  logic [IDX_W-1:0] in_a, in_b;
  logic [31:0]      in_dist;
  logic             in_ok, accept;
  logic             same;
  logic             last_step, add_sat, copy_b;
  logic [31:0]      hmr;
  logic [32:0]      hpr;
  logic [OP_W-1:0]  dsum, dir_sel;
  logic [39:0]      pa_sel, pb_sel;
  sdp_usum_t        usum_a, usum_b;
  sdp_psum_t        psum_a, psum_b;

  assign in_a    = s_axis_tdata[9:0];
  assign in_b    = s_axis_tdata[19:10];
  assign in_dist = s_axis_tdata[83:52];

  always_comb begin
    case (s_axis_tuser)
      ACT_LOAD, ACT_INV, ACT_READ: in_ok = 32'(in_a) < MAX_PARTICLES;
      ACT_DENS, ACT_PRES: in_ok = (32'(in_a) < MAX_PARTICLES) &&
                                  (32'(in_b) < MAX_PARTICLES) && (in_dist < radius_q);
      default: in_ok = 1'b0;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign same          = (ia_q == ib_q);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      rest_q   <= REST_RST;
      poly6_q  <= POLY6_RST;
      spiky_q  <= SPIKY_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_RADIUS: radius_q <= cfg_data_i;
        CFG_REST:   rest_q   <= cfg_data_i;
        CFG_POLY6:  poly6_q  <= cfg_data_i;
        CFG_SPIKY:  spiky_q  <= cfg_data_i;
        default:    radius_q <= radius_q;
      endcase
    end
  end

  // particle table
  assign raddr  = (state_q == ST_RDA) ? ia_q[PIDX_W-1:0] : ib_q[PIDX_W-1:0];
  assign waddr  = (state_q == ST_WRA) ? ia_q[PIDX_W-1:0] : ib_q[PIDX_W-1:0];
  assign mem_we = (state_q == ST_WRA) || (state_q == ST_WRB);

  always_comb begin
    wdata     = (state_q == ST_WRA) ? rec_a_q : rec_b_q;
    wdata.sat = wdata.sat | hit_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  // operand selection for the shared multiplier
  assign hmr  = radius_q - dist_q;
  assign hpr  = {1'b0, radius_q} + {1'b0, dist_q};
  assign dsum = {10'b0, rec_a_q.dens} - {10'b0, rest_q} + {10'b0, rec_b_q.dens}
              - {10'b0, rest_q};

  always_comb begin
    case (step_q)
      4'd5, 4'd10: dir_sel = {{24{dx_q[17]}}, dx_q};
      4'd6, 4'd11: dir_sel = {{24{dy_q[17]}}, dy_q};
      default:     dir_sel = {{24{dz_q[17]}}, dz_q};
    endcase
  end

  always_comb begin
    mreq.start = (state_q == ST_MGO);
    mreq.uns   = 1'b1;
    mreq.op_a  = '0;
    mreq.op_b  = '0;
    if (act_q == ACT_DENS) begin
      case (step_q)
        4'd0: begin
          mreq.op_a = {10'b0, hmr};
          mreq.op_b = {9'b0, hpr};
        end
        4'd1: begin
          mreq.op_a = t0_q;
          mreq.op_b = t0_q;
        end
        4'd2: begin
          mreq.op_a = t1_q;
          mreq.op_b = t0_q;
        end
        4'd3: begin
          mreq.op_a = t1_q;
          mreq.op_b = {10'b0, poly6_q};
        end
        4'd4: begin
          mreq.op_a = {10'b0, rec_b_q.mass};
          mreq.op_b = t0_q;
        end
        default: begin
          mreq.op_a = {10'b0, rec_a_q.mass};
          mreq.op_b = t0_q;
        end
      endcase
    end else begin
      case (step_q)
        4'd0: begin
          mreq.op_a = {10'b0, hmr};
          mreq.op_b = {10'b0, hmr};
        end
        4'd1: begin
          mreq.uns  = 1'b0;
          mreq.op_a = {{10{spiky_q[31]}}, spiky_q};
          mreq.op_b = t0_q;
        end
        4'd2: begin
          mreq.uns  = 1'b0;
          mreq.op_a = dsum;
          mreq.op_b = t0_q;
        end
        4'd3: begin
          mreq.op_a = {10'b0, rec_b_q.mass};
          mreq.op_b = {10'b0, rec_b_q.inv};
        end
        4'd8: begin
          mreq.op_a = {10'b0, rec_a_q.mass};
          mreq.op_b = {10'b0, rec_a_q.inv};
        end
        4'd4, 4'd9: begin
          mreq.uns  = 1'b0;
          mreq.op_a = t1_q;
          mreq.op_b = t0_q;
        end
        4'd5, 4'd6, 4'd7: begin
          mreq.uns  = 1'b0;
          mreq.op_a = dir_sel;
          mreq.op_b = t1_q;
        end
        default: begin
          // second particle takes the mirrored direction
          mreq.uns  = 1'b0;
          mreq.op_a = '0 - dir_sel;
          mreq.op_b = t1_q;
        end
      endcase
    end
  end

  sdp_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  assign div_start = (state_q == ST_DISP) && (act_q == ACT_INV) && (rec_a_q.dens != '0);

  sdp_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .den_i   (rec_a_q.dens),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // applying a product result
  always_comb begin
    case (step_q)
      4'd5:    pa_sel = rec_a_q.px;
      4'd6:    pa_sel = rec_a_q.py;
      default: pa_sel = rec_a_q.pz;
    endcase
    case (step_q)
      4'd10:   pb_sel = rec_b_q.px;
      4'd11:   pb_sel = rec_b_q.py;
      default: pb_sel = rec_b_q.pz;
    endcase
    usum_a  = add_dens(rec_a_q.dens, mrsp.res[31:0]);
    usum_b  = add_dens(rec_b_q.dens, mrsp.res[31:0]);
    psum_a  = add_pres(pa_sel, mrsp.res);
    psum_b  = add_pres(pb_sel, mrsp.res);
    rec_a_n = rec_a_q;
    rec_b_n = rec_b_q;
    t0_n    = t0_q;
    t1_n    = t1_q;
    add_sat = 1'b0;
    copy_b  = 1'b0;
    if (act_q == ACT_DENS) begin
      last_step = (step_q == DENS_LAST);
      case (step_q)
        4'd0, 4'd3: t0_n = mrsp.res;
        4'd1, 4'd2: t1_n = mrsp.res;
        4'd4: begin
          rec_a_n.dens = usum_a.val;
          add_sat      = usum_a.sat;
          copy_b       = same;
        end
        default: begin
          rec_b_n.dens = usum_b.val;
          add_sat      = usum_b.sat;
        end
      endcase
    end else begin
      last_step = (step_q == PRES_LAST);
      case (step_q)
        4'd0, 4'd1, 4'd2: t0_n = mrsp.res;
        4'd3, 4'd8:       t1_n = {1'b0, mrsp.res[OP_W-1:1]};
        4'd4, 4'd9:       t1_n = mrsp.res;
        4'd5: begin
          rec_a_n.px = psum_a.val;
          add_sat    = psum_a.sat;
        end
        4'd6: begin
          rec_a_n.py = psum_a.val;
          add_sat    = psum_a.sat;
        end
        4'd7: begin
          rec_a_n.pz = psum_a.val;
          add_sat    = psum_a.sat;
          copy_b     = same;
        end
        4'd10: begin
          rec_b_n.px = psum_b.val;
          add_sat    = psum_b.sat;
        end
        4'd11: begin
          rec_b_n.py = psum_b.val;
          add_sat    = psum_b.sat;
        end
        default: begin
          rec_b_n.pz = psum_b.val;
          add_sat    = psum_b.sat;
        end
      endcase
    end
  end

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept && in_ok) state_d = ST_RDA;
      ST_RDA:   state_d = ST_RDB;
      ST_RDB:   state_d = ST_RDC;
      ST_RDC:   state_d = ST_DISP;
      ST_DISP: begin
        case (act_q)
          ACT_LOAD:           state_d = ST_WRA;
          ACT_DENS, ACT_PRES: state_d = ST_MGO;
          ACT_INV:            state_d = div_start ? ST_DWAIT : ST_WRA;
          default:            state_d = ST_OUT;
        endcase
      end
      ST_MGO:   state_d = ST_MWAIT;
      ST_MWAIT: if (mrsp.done) state_d = last_step ? ST_WRA : ST_MGO;
      ST_DWAIT: if (div_done) state_d = ST_WRA;
      ST_WRA:   state_d = ((act_q == ACT_DENS) || (act_q == ACT_PRES)) ? ST_WRB : ST_IDLE;
      ST_WRB:   state_d = ST_IDLE;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= 4'd0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        hit_q <= 1'b0;
      end else if ((state_q == ST_DISP) && (act_q == ACT_INV) && !div_start) begin
        hit_q <= 1'b1;
      end else if ((state_q == ST_MWAIT) && mrsp.done) begin
        hit_q <= hit_q | mrsp.sat | add_sat;
      end else if ((state_q == ST_DWAIT) && div_done) begin
        hit_q <= hit_q | div_quo[32];
      end
      if (state_q == ST_DISP) begin
        step_q <= 4'd0;
      end else if ((state_q == ST_MWAIT) && mrsp.done) begin
        step_q <= step_q + 4'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= s_axis_tuser;
      ia_q   <= in_a;
      ib_q   <= in_b;
      mass_q <= s_axis_tdata[51:20];
      dist_q <= in_dist;
      dx_q   <= s_axis_tdata[101:84];
      dy_q   <= s_axis_tdata[119:102];
      dz_q   <= s_axis_tdata[137:120];
    end
    if (state_q == ST_RDB) begin
      rec_a_q <= rd_q;
    end else if (state_q == ST_DISP) begin
      if (act_q == ACT_LOAD) begin
        rec_a_q.mass <= mass_q;
        rec_a_q.dens <= mass_q;
        rec_a_q.px   <= '0;
        rec_a_q.py   <= '0;
        rec_a_q.pz   <= '0;
        rec_a_q.sat  <= 1'b0;
      end else if ((act_q == ACT_INV) && !div_start) begin
        rec_a_q.inv <= U32_MAX;
      end
    end else if ((state_q == ST_MWAIT) && mrsp.done) begin
      rec_a_q <= rec_a_n;
    end else if ((state_q == ST_DWAIT) && div_done) begin
      rec_a_q.inv <= div_quo[32] ? U32_MAX : div_quo[31:0];
    end
    if (state_q == ST_RDC) begin
      rec_b_q <= rd_q;
    end else if ((state_q == ST_MWAIT) && mrsp.done) begin
      // same particle twice: the second role sees the first role's update
      rec_b_q <= copy_b ? rec_a_n : rec_b_n;
    end
    if ((state_q == ST_MWAIT) && mrsp.done) begin
      t0_q <= t0_n;
      t1_q <= t1_n;
    end
    if (out_load) begin
      out_idx_q <= ia_q;
      out_rec_q <= rec_a_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_rec_q.sat, out_rec_q.pz, out_rec_q.py, out_rec_q.px,
                          out_rec_q.dens, out_idx_q};

endmodule

// ----- rtl/sdp_mul.sv -----
// shared q16.16 multiplier: three 42x14 partial products accumulated in turn, shift and saturate
module sdp_mul import sdp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sdp_mreq_t req_i,
  output sdp_mrsp_t rsp_o
);

  logic [OP_W-1:0]    mag_a_q, mag_b_q;
  logic               neg_q, uns_q;
  logic [ACC_W-1:0]   acc_q;
  logic [1:0]         cnt_q;
  logic               busy_q, fin_q, done_q;
  logic [OP_W-1:0]    res_q;
  logic               sat_q;
  logic [CHUNK_W-1:0] chunk;
  logic [OP_W+CHUNK_W-1:0] pp;
  logic [ACC_W-1:0]   pp_sh;
  logic [SHR_W-1:0]   shr, lim;
  logic               over;
  logic [OP_W-1:0]    mag_r;

  always_comb begin
    case (cnt_q)
      2'd0:    chunk = mag_b_q[CHUNK_W-1:0];
      2'd1:    chunk = mag_b_q[2*CHUNK_W-1:CHUNK_W];
      default: chunk = mag_b_q[3*CHUNK_W-1:2*CHUNK_W];
    endcase
    pp = {{CHUNK_W{1'b0}}, mag_a_q} * {{OP_W{1'b0}}, chunk};
    case (cnt_q)
      2'd0:    pp_sh = ACC_W'(pp);
      2'd1:    pp_sh = ACC_W'(pp) << CHUNK_W;
      default: pp_sh = ACC_W'(pp) << (2 * CHUNK_W);
    endcase
    shr = acc_q[ACC_W-1:16];
    if (uns_q) begin
      lim = LIM_U;
    end else if (neg_q) begin
      lim = LIM_SNEG;
    end else begin
      lim = LIM_SPOS;
    end
    over  = shr > lim;
    mag_r = over ? lim[OP_W-1:0] : shr[OP_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        if (cnt_q == 2'd2) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 2'd1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mag_a_q <= req_i.op_a[OP_W-1] ? ('0 - req_i.op_a) : req_i.op_a;
      mag_b_q <= req_i.op_b[OP_W-1] ? ('0 - req_i.op_b) : req_i.op_b;
      neg_q   <= req_i.op_a[OP_W-1] ^ req_i.op_b[OP_W-1];
      uns_q   <= req_i.uns;
      acc_q   <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
    if (fin_q) begin
      res_q <= neg_q ? ('0 - mag_r) : mag_r;
      sat_q <= over;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sat  = sat_q;
  assign rsp_o.res  = res_q;

endmodule

// ----- rtl/sdp_recip.sv -----
// restoring divider for 2^32 / density, one quotient bit a cycle
module sdp_recip import sdp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [32:0] quo_o
);

  logic [31:0] den_q, rem_q;
  logic [32:0] quo_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] trial;
  logic        take;

  always_comb begin
    // dividend is a single one at bit 32, fed first
    trial = {rem_q, (cnt_q == 6'd0)};
    take  = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        if (cnt_q == 6'd32) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? 32'(trial - {1'b0, den_q}) : trial[31:0];
      quo_q <= {quo_q[31:0], take};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- rtl/sdp_checker.sv -----
// port-level checks for the sph density/pressure engine, bound to the top level
module sdp_checker import sdp_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // ready only drops right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("input ready dropped without an accepted word");

  // a new output word only comes out of the busy sequencer
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("output word appeared while idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output word changed");

  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:163] == '0))
    else $error("output padding bits not zero");

endmodule

bind sph_density_pressure_engine sdp_checker u_sdp_checker (.*);

// ----- test/sph_density_pressure_engine_test.sv -----
// testbench for sph_density_pressure_engine: stream stimulus, in-bench predictor, field checks
module sph_density_pressure_engine_test;
  import sdp_pkg::*;

  localparam longint PRES_HI = 64'sd549755813887;
  localparam longint PRES_LO = -64'sd549755813888;
  localparam logic [63:0] DENS_HI = 64'h0000_0000_FFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned POOL_N = 24;

  typedef struct {
    logic [9:0]  idx;
    logic [31:0] dens;
    logic [39:0] px;
    logic [39:0] py;
    logic [39:0] pz;
    logic        sat;
  } particle_view_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [ACT_W-1:0]       s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [CFG_AW-1:0]      cfg_addr_i;
  logic [31:0]            cfg_data_i;

  sph_density_pressure_engine uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i), .cfg_addr_i(cfg_addr_i), .cfg_data_i(cfg_data_i)
  );

  // predictor copy of registers and particle table
  logic [31:0]        radius_q, rest_q, poly6_q, spiky_q;
  logic [31:0]        mass_tbl [MAX_PARTICLES];
  logic [31:0]        dens_tbl [MAX_PARTICLES];
  logic [31:0]        inv_tbl  [MAX_PARTICLES];
  longint             px_tbl   [MAX_PARTICLES];
  longint             py_tbl   [MAX_PARTICLES];
  longint             pz_tbl   [MAX_PARTICLES];
  logic               sat_tbl  [MAX_PARTICLES];
  bit                 sat_hit;

  particle_view_t     pending_reads[$];
  int unsigned        error_count;
  int unsigned        words_sent;
  int unsigned        reads_checked;
  int unsigned        settings_used;
  int unsigned        cycle_count;
  int unsigned        burst_left;
  bit                 gaps_on;
  int unsigned        stall_mode;
  logic [9:0]         pool [POOL_N];

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ((cycle_count % 16) < 5);
      default: m_axis_tready <= ((cycle_count % 64) > 40);
    endcase
  end

  // ---------------------------------------------------------------- arithmetic

  // (a*b)>>16 limited to lim
  function automatic logic [63:0] scaled_mag(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> 16;
    if (p > {64'b0, lim}) begin
      sat_hit = 1'b1;
      return lim;
    end
    return p[63:0];
  endfunction

  function automatic longint scaled_signed(longint a, longint b);
    bit          neg;
    logic [63:0] ma, mb, m;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m = scaled_mag(ma, mb, neg ? PRES_HI + 1 : PRES_HI);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] dens_add(logic [31:0] d, logic [63:0] t);
    logic [63:0] s;
    s = {32'b0, d} + t;
    if (s > DENS_HI) begin
      sat_hit = 1'b1;
      return DENS_HI[31:0];
    end
    return s[31:0];
  endfunction

  function automatic longint pres_add(longint p, longint t);
    longint s;
    s = p + t;
    if (s > PRES_HI) begin sat_hit = 1'b1; return PRES_HI; end
    if (s < PRES_LO) begin sat_hit = 1'b1; return PRES_LO; end
    return s;
  endfunction

  // table update for one accepted word; a read leaves an expected view behind
  function automatic void apply_word(logic [2:0] act, logic [9:0] a, logic [9:0] b,
                                     logic [31:0] m, logic [31:0] r,
                                     logic signed [17:0] dx, logic signed [17:0] dy,
                                     logic signed [17:0] dz);
    logic [63:0]    d2, d4, d6, w, hr, f;
    longint         sum, k, coef, g;
    particle_view_t v;
    sat_hit = 1'b0;
    case (act)
      ACT_LOAD: begin
        mass_tbl[a] = m;
        dens_tbl[a] = m;
        px_tbl[a] = 0;
        py_tbl[a] = 0;
        pz_tbl[a] = 0;
        sat_tbl[a] = 1'b0;
      end
      ACT_DENS: if (r < radius_q) begin
        d2 = ({32'b0, radius_q} * {32'b0, radius_q} - {32'b0, r} * {32'b0, r}) >> 16;
        if (d2 > DENS_HI) begin sat_hit = 1'b1; d2 = DENS_HI; end
        d4 = scaled_mag(d2, d2, DENS_HI);
        d6 = scaled_mag(d4, d2, DENS_HI);
        w = scaled_mag(d6, {32'b0, poly6_q}, DENS_HI);
        dens_tbl[a] = dens_add(dens_tbl[a], scaled_mag({32'b0, mass_tbl[b]}, w, DENS_HI));
        dens_tbl[b] = dens_add(dens_tbl[b], scaled_mag({32'b0, mass_tbl[a]}, w, DENS_HI));
        if (sat_hit) begin sat_tbl[a] = 1'b1; sat_tbl[b] = 1'b1; end
      end
      ACT_INV: begin
        if (dens_tbl[a] == 0) begin
          sat_hit = 1'b1;
          d2 = DENS_HI;
        end else begin
          d2 = 64'h1_0000_0000 / {32'b0, dens_tbl[a]};
          if (d2 > DENS_HI) begin sat_hit = 1'b1; d2 = DENS_HI; end
        end
        inv_tbl[a] = d2[31:0];
        if (sat_hit) sat_tbl[a] = 1'b1;
      end
      ACT_PRES: if (r < radius_q) begin
        sum = (longint'({32'b0, dens_tbl[a]}) - longint'({32'b0, rest_q}))
            + (longint'({32'b0, dens_tbl[b]}) - longint'({32'b0, rest_q}));
        hr = {32'b0, radius_q - r};
        k = scaled_signed(longint'($signed(spiky_q)), longint'(scaled_mag(hr, hr, DENS_HI)));
        coef = scaled_signed(sum, k);
        f = scaled_mag({32'b0, mass_tbl[b]}, {32'b0, inv_tbl[b]}, DENS_HI) >> 1;
        g = scaled_signed(longint'(f), coef);
        px_tbl[a] = pres_add(px_tbl[a], scaled_signed(longint'(dx), g));
        py_tbl[a] = pres_add(py_tbl[a], scaled_signed(longint'(dy), g));
        pz_tbl[a] = pres_add(pz_tbl[a], scaled_signed(longint'(dz), g));
        f = scaled_mag({32'b0, mass_tbl[a]}, {32'b0, inv_tbl[a]}, DENS_HI) >> 1;
        g = scaled_signed(longint'(f), coef);
        px_tbl[b] = pres_add(px_tbl[b], scaled_signed(-longint'(dx), g));
        py_tbl[b] = pres_add(py_tbl[b], scaled_signed(-longint'(dy), g));
        pz_tbl[b] = pres_add(pz_tbl[b], scaled_signed(-longint'(dz), g));
        if (sat_hit) begin sat_tbl[a] = 1'b1; sat_tbl[b] = 1'b1; end
      end
      ACT_READ: begin
        v.idx = a;
        v.dens = dens_tbl[a];
        v.px = px_tbl[a][39:0];
        v.py = py_tbl[a][39:0];
        v.pz = pz_tbl[a][39:0];
        v.sat = sat_tbl[a];
        pending_reads.push_back(v);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_word(logic [2:0] act, logic [9:0] a, logic [9:0] b, logic [31:0] m,
                           logic [31:0] r, logic signed [17:0] dx, logic signed [17:0] dy,
                           logic signed [17:0] dz);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {6'b0, dz, dy, dx, r, m, b, a};
    apply_word(act, a, b, m, r, dx, dy, dz);
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left > 0) burst_left--;
    if (act <= ACT_READ) words_sent++;
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_RADIUS: radius_q = value;
      CFG_REST:   rest_q = value;
      CFG_POLY6:  poly6_q = value;
      default:    spiky_q = value;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // drop valid, drain every read, then let the last pair finish
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] h, logic [31:0] rest, logic [31:0] p6, logic [31:0] sp);
    wait_idle();
    write_reg(CFG_RADIUS, h);
    write_reg(CFG_REST, rest);
    write_reg(CFG_POLY6, p6);
    write_reg(CFG_SPIKY, sp);
    settings_used++;
  endtask

  // ---------------------------------------------------------------- checker

  task automatic report_mismatch(string field, logic [9:0] idx, logic [63:0] got,
                                 logic [63:0] want);
    error_count++;
    if (error_count <= 30)
      $display("mismatch %s particle %0d: got %h expected %h", field, idx, got, want);
  endtask

  always @(posedge clk_i) begin
    particle_view_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_reads.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata[9:0], m_axis_tdata[63:0], 64'(0));
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        if (m_axis_tdata[9:0] !== want.idx)
          report_mismatch("index", want.idx, 64'(m_axis_tdata[9:0]), 64'(want.idx));
        if (m_axis_tdata[41:10] !== want.dens)
          report_mismatch("density", want.idx, 64'(m_axis_tdata[41:10]), 64'(want.dens));
        if (m_axis_tdata[81:42] !== want.px)
          report_mismatch("pressure x", want.idx, 64'(m_axis_tdata[81:42]), 64'(want.px));
        if (m_axis_tdata[121:82] !== want.py)
          report_mismatch("pressure y", want.idx, 64'(m_axis_tdata[121:82]), 64'(want.py));
        if (m_axis_tdata[161:122] !== want.pz)
          report_mismatch("pressure z", want.idx, 64'(m_axis_tdata[161:122]), 64'(want.pz));
        if (m_axis_tdata[162] !== want.sat)
          report_mismatch("saturated", want.idx, 64'(m_axis_tdata[162]), 64'(want.sat));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  function automatic logic signed [17:0] rand_dir();
    return 18'($signed($urandom_range(0, 131072)) - 65536);
  endfunction

  function automatic logic [31:0] rand_mass();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return $urandom_range(0, 32'h0004_0000);
  endfunction

  function automatic logic [31:0] rand_dist();
    if (radius_q == 0 || $urandom_range(0, 9) == 0) return $urandom();
    if ($urandom_range(0, 9) == 0) return radius_q;
    return $urandom_range(0, radius_q - 1);
  endfunction

  task automatic test_directed_cases();
    // zero mass, max mass, unit mass, two, and a tiny mass for the quotient overflow
    send_word(ACT_LOAD, 0, 0, 32'h0, 0, 0, 0, 0);
    send_word(ACT_LOAD, 1, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_word(ACT_LOAD, 2, 0, 32'h0001_0000, 0, 0, 0, 0);
    send_word(ACT_LOAD, 3, 0, 32'h0002_0000, 0, 0, 0, 0);
    send_word(ACT_LOAD, 4, 0, 32'h1, 0, 0, 0, 0);
    send_word(ACT_INV, 0, 0, 0, 0, 0, 0, 0);
    send_word(ACT_INV, 4, 0, 0, 0, 0, 0, 0);
    send_word(ACT_INV, 1, 0, 0, 0, 0, 0, 0);
    send_word(ACT_DENS, 2, 3, 0, 32'h0, 0, 0, 0);
    send_word(ACT_DENS, 2, 3, 0, radius_q, 0, 0, 0);
    send_word(ACT_DENS, 2, 3, 0, 32'hFFFF_FFFF, 0, 0, 0);
    send_word(ACT_DENS, 2, 2, 0, 32'h0000_8000, 0, 0, 0);
    send_word(ACT_DENS, 1, 1, 0, 32'h0, 0, 0, 0);
    send_word(ACT_INV, 2, 0, 0, 0, 0, 0, 0);
    send_word(ACT_INV, 3, 0, 0, 0, 0, 0, 0);
    send_word(ACT_PRES, 2, 3, 0, 32'h0000_4000, 18'sd65536, -18'sd65536, 18'sd0);
    send_word(ACT_PRES, 3, 3, 0, 32'h0, -18'sd65536, 18'sd65536, 18'sd46341);
    send_word(ACT_PRES, 1, 2, 0, 32'h0, 18'sd65536, 18'sd65536, -18'sd65536);
    send_word(ACT_PRES, 2, 3, 0, radius_q, 18'sd65536, 0, 0);
    send_word(3'd5, 2, 3, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_word({ACT_W{1'b1}}, 1, 1, 0, 0, 0, 0, 0);
    for (int i = 0; i < 5; i++) send_word(ACT_READ, 10'(i), 0, 0, 0, 0, 0, 0);
  endtask

  // one phase of random traffic, ill-formed words included, on a fresh pool of particles
  task automatic test_random_traffic(int unsigned n);
    logic [2:0]  act;
    int unsigned pick;
    for (int i = 0; i < POOL_N; i++) begin
      pool[i] = $urandom_range(0, 1023);
      send_word(ACT_LOAD, pool[i], 0, rand_mass(), 0, 0, 0, 0);
    end
    for (int i = 0; i < POOL_N; i++) send_word(ACT_INV, pool[i], 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) act = ACT_LOAD;
      else if (pick < 38) act = ACT_DENS;
      else if (pick < 50) act = ACT_INV;
      else if (pick < 78) act = ACT_PRES;
      else if (pick < 96) act = ACT_READ;
      else act = 3'($urandom_range(ACT_READ + 1, {ACT_W{1'b1}}));
      send_word(act, pool[$urandom_range(0, POOL_N - 1)], pool[$urandom_range(0, POOL_N - 1)],
                rand_mass(), rand_dist(), rand_dir(), rand_dir(), rand_dir());
    end
    for (int i = 0; i < POOL_N; i++) send_word(ACT_READ, pool[i], 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_default_registers();
    gaps_on = 1'b0;
    stall_mode = 0;
    test_directed_cases();
    gaps_on = 1'b1;
    stall_mode = 1;
    test_random_traffic(200);
  endtask

  task automatic test_register_extremes();
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    stall_mode = 2;
    test_random_traffic(200);
    set_regs(32'h0, 32'h0, 32'h0, 32'h8000_0000);
    stall_mode = 3;
    test_random_traffic(120);
    set_regs(32'h0004_0000, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000);
    stall_mode = 0;
    gaps_on = 1'b0;
    test_random_traffic(200);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_registers();
    for (int s = 0; s < 3; s++) begin
      set_regs($urandom_range(32'h0000_8000, 32'h0004_0000), $urandom_range(0, 32'h0008_0000),
               $urandom_range(0, 32'h0010_0000), $urandom());
      stall_mode = $urandom_range(0, 3);
      test_random_traffic(160);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ACT_LOAD;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = CFG_RADIUS;
    cfg_data_i = '0;
    cycle_count = 0;
    error_count = 0;
    words_sent = 0;
    reads_checked = 0;
    settings_used = 1;
    burst_left = 0;
    gaps_on = 1'b0;
    stall_mode = 0;
    radius_q = RADIUS_RST;
    rest_q = REST_RST;
    poly6_q = POLY6_RST;
    spiky_q = SPIKY_RST;
    for (int i = 0; i < MAX_PARTICLES; i++) begin
      mass_tbl[i] = 0; dens_tbl[i] = 0; inv_tbl[i] = 0;
      px_tbl[i] = 0; py_tbl[i] = 0; pz_tbl[i] = 0; sat_tbl[i] = 1'b0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_registers();
    test_register_extremes();
    test_random_registers();
    wait_idle();

    $display("sent %0d words over %0d register settings, checked %0d particle reads",
             words_sent, settings_used, reads_checked);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
